// File: rtl/brps_pkg.sv
`timescale 1ns / 1ps

package brps_pkg;

  localparam int GainW = 32;
  localparam int LimitW = 15;
  localparam int CfgIdxW = 3;
  localparam int DriveW = 32;

  // Operand magnitude, multiplier halves and product widths.
  localparam int OperW = 35;
  localparam int MagW = 34;
  localparam int HalfW = 17;
  localparam int ProdW = HalfW + GainW;
  localparam int MaccW = 2 * HalfW + GainW;
  localparam int FracW = 16;
  localparam int TermW = MaccW - FracW;
  localparam int SumW = 54;

  localparam int StepW = 5;
  localparam int IssueSteps = 16;
  localparam int FiltStep = 4;
  localparam int IntegStep = 5;
  localparam int LastStep = 17;

  localparam logic [GainW-1:0] BalPropReset = 32'd14417920;
  localparam logic [GainW-1:0] BalDerivReset = 32'd91750;
  localparam logic [GainW-1:0] SpdPropReset = 32'd5898240;
  localparam logic [GainW-1:0] SpdIntegReset = 32'd6554;
  localparam logic [GainW-1:0] SpdDerivReset = 32'd0;
  localparam logic [GainW-1:0] TrnPropReset = 32'd45875;
  localparam logic [GainW-1:0] TrnDerivReset = 32'd19661;
  localparam logic [LimitW-1:0] StopTiltReset = 15'd10240;

  localparam logic [GainW-1:0] LpfCoef = 32'd45875;
  localparam logic signed [DriveW-1:0] TurnScale = 32'sd6553600;
  localparam logic [16:0] FwdScaleInt = 17'd78643;
  localparam logic [15:0] DivFiveMul = 16'd205;
  localparam int DivFiveShift = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BALANCE_PROP,
    CFG_BALANCE_DERIV,
    CFG_SPEED_PROP,
    CFG_SPEED_INTEG,
    CFG_SPEED_DERIV,
    CFG_TURN_PROP,
    CFG_TURN_DERIV,
    CFG_STOP_TILT
  } cfg_idx_t;

  // The products are issued in this order, two multiplier passes each.
  typedef enum logic [2:0] {
    OP_LPF,
    OP_BAL_P,
    OP_BAL_D,
    OP_TRN_P,
    OP_TRN_D,
    OP_SPD_P,
    OP_SPD_D,
    OP_SPD_I
  } op_sel_t;

  typedef enum logic [1:0] {
    DEST_LPF,
    DEST_BAL,
    DEST_SPD,
    DEST_TRN
  } dest_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [GainW-1:0]  balance_prop_gain;
    logic [GainW-1:0]  balance_deriv_gain;
    logic [GainW-1:0]  speed_prop_gain;
    logic [GainW-1:0]  speed_integ_gain;
    logic [GainW-1:0]  speed_deriv_gain;
    logic [GainW-1:0]  turn_prop_gain;
    logic [GainW-1:0]  turn_deriv_gain;
    logic [LimitW-1:0] stop_tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic    load;
    logic    issue;
    logic    hi;
    op_sel_t opsel;
    logic    sat_filt;
    logic    upd_integ;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic  valid;
    logic  hi;
    dest_t dest;
    logic  neg;
  } mul_tag_t;

  function automatic logic signed [DriveW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic [SumW-DriveW:0] top;
    top = v[SumW-1:DriveW-1];
    if ((&top) || !(|top)) begin
      return v[DriveW-1:0];
    end else if (v[SumW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // Speed setpoint of 1.2 per stick unit, truncated toward zero.
  function automatic logic signed [DriveW-1:0] fwd_target(input logic signed [6:0] stick);
    logic signed [7:0] wide;
    logic [7:0]        mag;
    logic [24:0]       whole;
    logic [15:0]       fifth;
    logic [24:0]       total;
    wide = 8'(stick);
    mag = wide[7] ? 8'(-wide) : 8'(wide);
    whole = 25'(mag) * 25'(FwdScaleInt);
    fifth = 16'(mag) * DivFiveMul;
    total = whole + 25'(fifth >> DivFiveShift);
    if (stick[6]) begin
      return -32'(total);
    end else begin
      return 32'(total);
    end
  endfunction

  function automatic dest_t dest_of(input op_sel_t opsel);
    case (opsel)
      OP_LPF:   return DEST_LPF;
      OP_BAL_P: return DEST_BAL;
      OP_BAL_D: return DEST_BAL;
      OP_TRN_P: return DEST_TRN;
      OP_TRN_D: return DEST_TRN;
      default:  return DEST_SPD;
    endcase
  endfunction

endpackage

// File: rtl/brps_cfg.sv
`timescale 1ns / 1ps

module brps_cfg import brps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [GainW-1:0]   cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.balance_prop_gain  <= BalPropReset;
      cfg.balance_deriv_gain <= BalDerivReset;
      cfg.speed_prop_gain    <= SpdPropReset;
      cfg.speed_integ_gain   <= SpdIntegReset;
      cfg.speed_deriv_gain   <= SpdDerivReset;
      cfg.turn_prop_gain     <= TrnPropReset;
      cfg.turn_deriv_gain    <= TrnDerivReset;
      cfg.stop_tilt_limit    <= StopTiltReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BALANCE_PROP:  cfg.balance_prop_gain  <= cfg_data;
        CFG_BALANCE_DERIV: cfg.balance_deriv_gain <= cfg_data;
        CFG_SPEED_PROP:    cfg.speed_prop_gain    <= cfg_data;
        CFG_SPEED_INTEG:   cfg.speed_integ_gain   <= cfg_data;
        CFG_SPEED_DERIV:   cfg.speed_deriv_gain   <= cfg_data;
        CFG_TURN_PROP:     cfg.turn_prop_gain     <= cfg_data;
        CFG_TURN_DERIV:    cfg.turn_deriv_gain    <= cfg_data;
        CFG_STOP_TILT:     cfg.stop_tilt_limit    <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/brps_ctrl.sv
`timescale 1ns / 1ps

module brps_ctrl import brps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t           state, state_next;
  logic [StepW-1:0] step, step_next;
  logic             out_free;
  logic             out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_valid_next = cmd.finish || (out_valid && out_stall);

  always_comb begin
    state_next = state;
    step_next = step;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        step_next = step + 1'b1;
        if (step == StepW'(LastStep)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.issue = (state == ST_RUN) && (step < StepW'(IssueSteps));
    cmd.hi = step[0];
    cmd.opsel = op_sel_t'(step[3:1]);
    cmd.sat_filt = (state == ST_RUN) && (step == StepW'(FiltStep));
    cmd.upd_integ = (state == ST_RUN) && (step == StepW'(IntegStep));
    cmd.finish = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Block did not turn busy after an input transfer.");

  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free)
    else $error("Result written while the output register was still held.");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("Output became valid without a finished tick.");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= StepW'(LastStep)))
    else $error("Step counter ran past the end of the schedule.");
`endif

endmodule

// File: rtl/brps_dp.sv
`timescale 1ns / 1ps

module brps_dp import brps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  cfg_t                     cfg,
  input  logic signed [15:0]       pitch_angle,
  input  logic signed [19:0]       pitch_rate,
  input  logic signed [19:0]       yaw_rate,
  input  logic signed [15:0]       wheel_speed,
  input  logic                     motor_enabled,
  input  logic signed [6:0]        stick_forward,
  input  logic signed [6:0]        stick_turn,
  output logic signed [DriveW-1:0] balance_drive,
  output logic signed [DriveW-1:0] speed_drive,
  output logic signed [DriveW-1:0] turn_drive
);

  logic signed [15:0] pitch;
  logic signed [19:0] prate;
  logic signed [19:0] yrate;
  logic signed [15:0] wspd;
  logic               motor_on;
  logic signed [6:0]  sfwd;
  logic signed [6:0]  sturn;

  logic signed [DriveW-1:0] speed_target;
  logic signed [DriveW-1:0] turn_target;
  logic signed [DriveW-1:0] filtered;
  logic signed [DriveW-1:0] speed_prev;
  logic signed [DriveW-1:0] integral;
  logic signed [DriveW-1:0] turn_prev;

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] lo;
  logic [MaccW-1:0] mag;
  mul_tag_t         tag1;
  mul_tag_t         tag2;

  logic signed [SumW-1:0] sum_lpf;
  logic signed [SumW-1:0] sum_bal;
  logic signed [SumW-1:0] sum_spd;
  logic signed [SumW-1:0] sum_trn;

  logic signed [OperW-1:0]  raw;
  logic signed [OperW-1:0]  lpf_oper;
  logic signed [OperW-1:0]  terr;
  logic signed [OperW-1:0]  oper;
  logic [GainW-1:0]         gain;
  logic [OperW-1:0]         oper_abs;
  logic [HalfW-1:0]         half;
  logic [TermW-1:0]         term;
  logic signed [SumW-1:0]   sum_sel;
  logic signed [SumW-1:0]   sum_new;
  logic signed [16:0]       pitch_x;
  logic [16:0]              abs_pitch;
  logic signed [DriveW-1:0] new_speed_target;
  logic                     clear_integ;

  assign raw = OperW'(signed'({wspd, 16'h0000})) - OperW'(speed_target);
  assign lpf_oper = raw - OperW'(filtered);
  assign terr = OperW'(turn_target) - OperW'(signed'({yrate, 8'h00}));

  always_comb begin
    case (cmd.opsel)
      OP_LPF: begin
        oper = lpf_oper;
        gain = LpfCoef;
      end
      OP_BAL_P: begin
        oper = OperW'(signed'({pitch, 8'h00}));
        gain = cfg.balance_prop_gain;
      end
      OP_BAL_D: begin
        oper = OperW'(signed'({prate, 8'h00}));
        gain = cfg.balance_deriv_gain;
      end
      OP_TRN_P: begin
        oper = terr;
        gain = cfg.turn_prop_gain;
      end
      OP_TRN_D: begin
        oper = terr - OperW'(turn_prev);
        gain = cfg.turn_deriv_gain;
      end
      OP_SPD_P: begin
        oper = OperW'(filtered);
        gain = cfg.speed_prop_gain;
      end
      OP_SPD_D: begin
        oper = OperW'(filtered) - OperW'(speed_prev);
        gain = cfg.speed_deriv_gain;
      end
      OP_SPD_I: begin
        oper = OperW'(integral);
        gain = cfg.speed_integ_gain;
      end
      default: begin
        oper = '0;
        gain = '0;
      end
    endcase
  end

  assign oper_abs = oper[OperW-1] ? -oper : oper;
  assign half = cmd.hi ? oper_abs[MagW-1:HalfW] : oper_abs[HalfW-1:0];

  // Products are truncated toward zero: magnitude first, sign applied at accumulation.
  assign term = mag[MaccW-1:FracW];

  always_comb begin
    case (tag2.dest)
      DEST_LPF: sum_sel = sum_lpf;
      DEST_BAL: sum_sel = sum_bal;
      DEST_SPD: sum_sel = sum_spd;
      DEST_TRN: sum_sel = sum_trn;
      default:  sum_sel = '0;
    endcase
    if (tag2.neg) begin
      sum_new = sum_sel - signed'(SumW'(term));
    end else begin
      sum_new = sum_sel + signed'(SumW'(term));
    end
  end

  assign pitch_x = 17'(pitch);
  assign abs_pitch = pitch_x[16] ? -pitch_x : pitch_x;
  assign new_speed_target = fwd_target(sfwd);
  assign clear_integ = (abs_pitch > 17'(cfg.stop_tilt_limit)) || !motor_on ||
                       (new_speed_target != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pitch <= pitch_angle;
      prate <= pitch_rate;
      yrate <= yaw_rate;
      wspd <= wheel_speed;
      motor_on <= motor_enabled;
      sfwd <= stick_forward;
      sturn <= stick_turn;
    end
  end

  always_ff @(posedge clk) begin
    prod <= half * gain;
    if (tag1.valid && !tag1.hi) begin
      lo <= prod;
    end
    if (tag1.valid && tag1.hi) begin
      mag <= {prod, {HalfW{1'b0}}} + MaccW'(lo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
    end else begin
      tag1.valid <= cmd.issue;
      tag1.hi <= cmd.hi;
      tag1.dest <= dest_of(cmd.opsel);
      tag1.neg <= oper[OperW-1];
      tag2.valid <= tag1.valid && tag1.hi;
      tag2.hi <= tag1.hi;
      tag2.dest <= tag1.dest;
      tag2.neg <= tag1.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_lpf <= SumW'(filtered);
      sum_bal <= '0;
      sum_spd <= '0;
      sum_trn <= '0;
    end else if (tag2.valid) begin
      case (tag2.dest)
        DEST_LPF: sum_lpf <= sum_new;
        DEST_BAL: sum_bal <= sum_new;
        DEST_SPD: sum_spd <= sum_new;
        DEST_TRN: sum_trn <= sum_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_target <= '0;
      turn_target <= '0;
      filtered <= '0;
      speed_prev <= '0;
      integral <= '0;
      turn_prev <= '0;
    end else begin
      if (cmd.sat_filt) begin
        filtered <= sat32(sum_lpf);
      end
      if (cmd.upd_integ) begin
        integral <= sat32(SumW'(integral) + SumW'(filtered));
      end
      if (cmd.finish) begin
        speed_prev <= filtered;
        turn_prev <= sat32(SumW'(terr));
        speed_target <= new_speed_target;
        turn_target <= -(32'(sturn) * TurnScale);
        if (clear_integ) begin
          integral <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      balance_drive <= sat32(sum_bal);
      speed_drive <= sat32(sum_spd);
      turn_drive <= sat32(sum_trn);
    end
  end

endmodule

// File: rtl/balance_robot_pid_step.sv
`timescale 1ns / 1ps

// Control tick of a two-wheel balancing robot: balance PD, speed PI-D on the
// low-pass filtered wheel-speed error, and turn PD, all in Q16.16.
// Input channel (in_valid / in_stall) carries one tick of sensor and stick
// data; a transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall) carries the three saturated drives.
// Gains and the tilt limit are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no tick is in flight, as the block itself
// does not enforce this. A new input is taken only once the previous tick's
// result is in the output register, at a pace set by the single
// shared 17x32 multiplier: eight products, two passes each, plus the pipeline
// tail of the accumulator.
// The input is stalled while a tick runs. A finished result waits in the
// output register; when the receiver stalls, the next tick runs but holds
// its result back until the register is free.
// Synchronous reset loads the default gains, clears all loop state and
// setpoints, and empties the output register.
module balance_robot_pid_step import brps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       pitch_angle,
  input  logic signed [19:0]       pitch_rate,
  input  logic signed [19:0]       yaw_rate,
  input  logic signed [15:0]       wheel_speed,
  input  logic                     motor_enabled,
  input  logic signed [6:0]        stick_forward,
  input  logic signed [6:0]        stick_turn,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DriveW-1:0] balance_drive,
  output logic signed [DriveW-1:0] speed_drive,
  output logic signed [DriveW-1:0] turn_drive,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [GainW-1:0]         cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  brps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  brps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .pitch_angle   (pitch_angle),
    .pitch_rate    (pitch_rate),
    .yaw_rate      (yaw_rate),
    .wheel_speed   (wheel_speed),
    .motor_enabled (motor_enabled),
    .stick_forward (stick_forward),
    .stick_turn    (stick_turn),
    .balance_drive (balance_drive),
    .speed_drive   (speed_drive),
    .turn_drive    (turn_drive)
  );

endmodule

// File: dv/balance_robot_pid_step_tb.sv
`timescale 1ns / 1ps

module balance_robot_pid_step_tb;
  import brps_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int PrintCap = 100;
  localparam logic [31:0] LpfGain = 32'd45875;
  localparam longint FwdNum = 3932160;
  localparam longint FwdDen = 50;
  localparam longint TurnStep = 6553600;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [19:0] prate;
    logic signed [19:0] yaw;
    logic signed [15:0] wheel;
    logic               motor;
    logic signed [6:0]  fwd;
    logic signed [6:0]  turn;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] bal;
    logic signed [31:0] spd;
    logic signed [31:0] trn;
  } drives_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] pitch_angle = '0;
  logic signed [19:0] pitch_rate = '0;
  logic signed [19:0] yaw_rate = '0;
  logic signed [15:0] wheel_speed = '0;
  logic motor_enabled = 1'b0;
  logic signed [6:0] stick_forward = '0;
  logic signed [6:0] stick_turn = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DriveW-1:0] balance_drive;
  logic signed [DriveW-1:0] speed_drive;
  logic signed [DriveW-1:0] turn_drive;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [GainW-1:0] cfg_data = '0;

  tick_t tick_q[$];
  drives_t drive_q[$];

  logic [31:0] reg_shadow [8];
  logic signed [31:0] spd_setpt, trn_setpt, spd_err_lp, spd_err_last, spd_accum, trn_err_last;

  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  balance_robot_pid_step dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pitch_angle(pitch_angle),
    .pitch_rate(pitch_rate),
    .yaw_rate(yaw_rate),
    .wheel_speed(wheel_speed),
    .motor_enabled(motor_enabled),
    .stick_forward(stick_forward),
    .stick_turn(stick_turn),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .balance_drive(balance_drive),
    .speed_drive(speed_drive),
    .turn_drive(turn_drive),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -longint'(64'h8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Signed Q16.16 value times unsigned Q16.16 gain, truncated toward zero.
  function automatic longint scale_q(longint a, logic [31:0] g);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    prod = mag * {48'd0, g[31:16]} + ((mag * {48'd0, g[15:0]}) >> 16);
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic drives_t run_tick(tick_t t);
    drives_t d;
    longint pitch, raw, diff, terr, absp;
    pitch = longint'(t.pitch);
    d.bal = clamp32(scale_q(pitch * 256, reg_shadow[CFG_BALANCE_PROP]) +
                    scale_q(longint'(t.prate) * 256, reg_shadow[CFG_BALANCE_DERIV]));

    raw = longint'(t.wheel) * 65536 - longint'(spd_setpt);
    spd_err_lp = clamp32(longint'(spd_err_lp) + scale_q(raw - longint'(spd_err_lp), LpfGain));
    spd_accum = clamp32(longint'(spd_accum) + longint'(spd_err_lp));
    diff = longint'(spd_err_lp) - longint'(spd_err_last);
    d.spd = clamp32(scale_q(longint'(spd_err_lp), reg_shadow[CFG_SPEED_PROP]) +
                    scale_q(longint'(spd_accum), reg_shadow[CFG_SPEED_INTEG]) +
                    scale_q(diff, reg_shadow[CFG_SPEED_DERIV]));
    spd_err_last = spd_err_lp;
    absp = (pitch < 0) ? -pitch : pitch;
    if (absp > longint'(reg_shadow[CFG_STOP_TILT]) || !t.motor) begin
      spd_accum = '0;
    end

    terr = longint'(trn_setpt) - longint'(t.yaw) * 256;
    diff = terr - longint'(trn_err_last);
    d.trn = clamp32(scale_q(terr, reg_shadow[CFG_TURN_PROP]) +
                    scale_q(diff, reg_shadow[CFG_TURN_DERIV]));
    trn_err_last = clamp32(terr);

    // The setpoints take effect on the next tick.
    spd_setpt = 32'((longint'(t.fwd) * FwdNum) / FwdDen);
    trn_setpt = 32'(-longint'(t.turn) * TurnStep);
    if (spd_setpt != 0) begin
      spd_accum = '0;
    end
    return d;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("ERROR: %s", msg);
    end
  endtask

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  always @(posedge clk) begin : driver
    int gap;
    tick_t cur;
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        drive_q.push_back(run_tick(cur));
        if ($urandom_range(0, 99) == 0) begin
          in_quiet = !in_quiet;
        end
        gap = (!in_quiet && $urandom_range(0, 99) < 40) ? pause_len() : 0;
      end
      if (in_valid && in_stall) begin
        // Hold the payload until the transfer.
      end else if (gap != 0) begin
        in_valid <= 1'b0;
        gap--;
      end else if (tick_q.size() != 0) begin
        cur = tick_q.pop_front();
        pitch_angle <= cur.pitch;
        pitch_rate <= cur.prate;
        yaw_rate <= cur.yaw;
        wheel_speed <= cur.wheel;
        motor_enabled <= cur.motor;
        stick_forward <= cur.fwd;
        stick_turn <= cur.turn;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    int stall_left;
    drives_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          note_failure($sformatf("result with no tick pending: %h %h %h",
                                 balance_drive, speed_drive, turn_drive));
        end else begin
          want = drive_q.pop_front();
          if (balance_drive !== want.bal) begin
            note_failure($sformatf("balance_drive transfer %0d: got %h, expected %h",
                                   results_seen, balance_drive, want.bal));
          end
          if (speed_drive !== want.spd) begin
            note_failure($sformatf("speed_drive transfer %0d: got %h, expected %h",
                                   results_seen, speed_drive, want.spd));
          end
          if (turn_drive !== want.trn) begin
            note_failure($sformatf("turn_drive transfer %0d: got %h, expected %h",
                                   results_seen, turn_drive, want.trn));
          end
        end
        results_seen++;
        if ($urandom_range(0, 49) == 0) begin
          out_quiet = !out_quiet;
        end
      end
      if (stall_left == 0 && !out_quiet && $urandom_range(0, 99) < 10) begin
        stall_left = pause_len();
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_reg(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    reg_shadow[idx] = (idx == CFG_STOP_TILT) ? {17'd0, data[14:0]} : data;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (tick_q.size() != 0 || in_valid || drive_q.size() != 0);
  endtask

  task automatic push_tick(int p, int pr, int y, int w, bit m, int f, int tr);
    tick_t t;
    t.pitch = 16'(p);
    t.prate = 20'(pr);
    t.yaw = 20'(y);
    t.wheel = 16'(w);
    t.motor = m;
    t.fwd = 7'(f);
    t.turn = 7'(tr);
    tick_q.push_back(t);
  endtask

  // Kind 0 holds the robot near upright with the forward stick centered, so the
  // speed integral builds up; kind 1 drives around; kind 2 is raw noise.
  function automatic tick_t random_tick(int kind);
    tick_t t;
    int span;
    t = tick_t'({$urandom, $urandom, $urandom});
    if (kind == 0) begin
      span = int'(reg_shadow[CFG_STOP_TILT]) + 64;
      if (span > 32767) begin
        span = 32767;
      end
      t.pitch = 16'(rand_span(span));
      t.prate = 20'(rand_span(4096));
      t.yaw = 20'(rand_span(4096));
      t.wheel = 16'(rand_span(300));
      t.motor = ($urandom_range(0, 99) < 97);
      t.fwd = '0;
      t.turn = ($urandom_range(0, 1) == 0) ? 7'(0) : 7'(rand_span(50));
    end else if (kind == 1) begin
      t.pitch = 16'(rand_span(3000));
      if ($urandom_range(0, 9) < 7) begin
        t.prate = 20'(rand_span(20000));
      end
      t.yaw = 20'(rand_span(20000));
      t.wheel = 16'(rand_span(2000));
      t.motor = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) != 0) begin
        t.fwd = 7'(rand_span(50));
        t.turn = 7'(rand_span(50));
      end
    end
    return t;
  endfunction

  task automatic queue_random(int count);
    int kind, left, r;
    left = 0;
    kind = 0;
    repeat (count) begin
      if (left == 0) begin
        r = $urandom_range(0, 9);
        kind = (r < 6) ? 0 : (r < 8) ? 1 : 2;
        left = $urandom_range(5, 40);
      end
      left--;
      tick_q.push_back(random_tick(kind));
    end
  endtask

  function automatic logic [31:0] random_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(0, 300 * 65536);
    end else if (r < 80) begin
      return $urandom_range(0, 262143);
    end
    return $urandom;
  endfunction

  initial begin
    reg_shadow[CFG_BALANCE_PROP] = BalPropReset;
    reg_shadow[CFG_BALANCE_DERIV] = BalDerivReset;
    reg_shadow[CFG_SPEED_PROP] = SpdPropReset;
    reg_shadow[CFG_SPEED_INTEG] = SpdIntegReset;
    reg_shadow[CFG_SPEED_DERIV] = SpdDerivReset;
    reg_shadow[CFG_TURN_PROP] = TrnPropReset;
    reg_shadow[CFG_TURN_DERIV] = TrnDerivReset;
    reg_shadow[CFG_STOP_TILT] = {17'd0, StopTiltReset};
    spd_setpt = '0;
    trn_setpt = '0;
    spd_err_lp = '0;
    spd_err_last = '0;
    spd_accum = '0;
    trn_err_last = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks under the reset gains.
    push_tick(0, 0, 0, 0, 1, 0, 0);
    push_tick(32767, 524287, 524287, 32767, 1, 0, 0);
    push_tick(-32768, -524288, -524288, -32768, 1, 0, 0);
    push_tick(10240, 100, -100, 100, 1, 0, 0);
    push_tick(-10240, -100, 100, 120, 1, 0, 0);
    push_tick(-10241, 0, 0, 100, 1, 0, 0);
    push_tick(10241, 0, 0, 100, 1, 0, 0);
    push_tick(0, 0, 0, 50, 0, 0, 0);
    push_tick(0, 0, 0, 50, 1, 63, -64);
    push_tick(0, 0, 0, 32767, 1, -64, 63);
    repeat (4) push_tick(0, 0, 0, 32767, 1, -64, 63);
    push_tick(0, 0, 0, 0, 1, 50, -50);
    push_tick(0, 0, 0, 0, 1, -50, 50);
    push_tick(0, 0, 0, 0, 1, 1, -1);
    push_tick(0, 0, 0, 0, 1, -1, 1);
    repeat (4) push_tick(5, 10, 10, -32768, 1, 0, 0);
    push_tick(5, 10, 10, -32768, 0, 0, 0);
    repeat (2) push_tick(0, 0, 0, 32767, 1, 0, 0);
    drain();

    // Every gain at full scale; the tilt limit drops the upper data bits.
    for (int i = 0; i <= int'(CFG_STOP_TILT); i++) begin
      set_reg(cfg_idx_t'(i), 32'hFFFF_FFFF);
    end
    end_writes();
    push_tick(32767, 524287, 524287, 32767, 1, 0, 0);
    push_tick(-32768, -524288, -524288, -32768, 1, 0, 0);
    push_tick(32767, 0, 0, 32767, 1, 63, -64);
    push_tick(-32767, 0, 0, -32768, 1, -64, 63);
    queue_random(120);
    drain();

    for (int i = 0; i <= int'(CFG_STOP_TILT); i++) begin
      set_reg(cfg_idx_t'(i), 32'h0);
    end
    end_writes();
    queue_random(100);
    drain();

    repeat (8) begin
      for (int i = 0; i < int'(CFG_STOP_TILT); i++) begin
        set_reg(cfg_idx_t'(i), random_gain());
      end
      set_reg(CFG_STOP_TILT, ($urandom_range(0, 1) == 0) ? $urandom :
                             $urandom_range(0, 12800));
      end_writes();
      queue_random(200);
      drain();
    end

    set_reg(CFG_BALANCE_PROP, BalPropReset);
    set_reg(CFG_BALANCE_DERIV, BalDerivReset);
    set_reg(CFG_SPEED_PROP, SpdPropReset);
    set_reg(CFG_SPEED_INTEG, SpdIntegReset);
    set_reg(CFG_SPEED_DERIV, SpdDerivReset);
    set_reg(CFG_TURN_PROP, TrnPropReset);
    set_reg(CFG_TURN_DERIV, TrnDerivReset);
    set_reg(CFG_STOP_TILT, {17'd0, StopTiltReset});
    end_writes();
    queue_random(60);
    drain();

    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
